// ===== hdl/refcounted_handle_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the handle allocator
// Shared property forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_HANDLE_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_HANDLE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define RHA_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define RHA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/rha_pkg.sv =====
// ----------------------------------------------------------------------------
// rha_pkg
// Types, widths and helpers shared by the handle allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rha_pkg;

  localparam int unsigned IDX_W   = 10;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned LIVE_W  = 11;
  localparam int unsigned SLAB_W  = 5;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned STAT_W  = 2;

  localparam int unsigned TABLE_DEPTH  = 1024;
  localparam int unsigned SLAB_ENTRIES = 64;
  localparam int unsigned MAX_SLABS    = 16;

  localparam logic [SLAB_W-1:0] SLAB_LIMIT_RST = SLAB_W'(16);
  localparam logic [CNT_W-1:0]  COUNT_MAX      = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_CREATE  = 2'd0,
    ACT_GET     = 2'd1,
    ACT_RETAIN  = 2'd2,
    ACT_RELEASE = 2'd3
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_DEAD     = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_state_e;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  function automatic logic [LIVE_W-1:0] cap_of(input logic [SLAB_W-1:0] slabs);
    int unsigned s;
    int unsigned c;
    s = int'(slabs);
    if (s > MAX_SLABS) begin
      s = MAX_SLABS;
    end
    c = s * SLAB_ENTRIES;
    if (c > TABLE_DEPTH) begin
      c = TABLE_DEPTH;
    end
    return LIVE_W'(c);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/refcounted_handle_allocator.sv =====
// ----------------------------------------------------------------------------
// refcounted_handle_allocator
// Reference-counted handle table with a LIFO free list of released entries.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low. It has a read
// step, which fetches the entry from the single-port entry memories, and a
// write-back step, during which busy is high and no new operation is taken.
// The result appears on the result ports, with done_o high for one cycle, in the
// cycle after the write-back. The receiver cannot stall and must take it
// then. No clearing pass runs after reset: entries at or above the fill index
// read as dead. Write cfg_wdata_i (slab limit) only while the block is idle.
`default_nettype none

module refcounted_handle_allocator
  import rha_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [ACT_W-1:0]  action_i,
  input  wire logic [IDX_W-1:0]  handle_i,
  input  wire logic [VAL_W-1:0]  oop_value_i,
  input  wire logic              cfg_we_i,
  input  wire logic [SLAB_W-1:0] cfg_wdata_i,
  output logic                   done_o,
  output logic [STAT_W-1:0]      status_o,
  output logic [IDX_W-1:0]       result_handle_o,
  output logic [VAL_W-1:0]       result_value_o,
  output logic [CNT_W-1:0]       ref_count_o,
  output logic [LIVE_W-1:0]      live_count_o
);

  ctrl_cmd_t cmd;

  rha_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  rha_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .action_i        (action_i),
    .handle_i        (handle_i),
    .oop_value_i     (oop_value_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .status_o        (status_o),
    .result_handle_o (result_handle_o),
    .result_value_o  (result_value_o),
    .ref_count_o     (ref_count_o),
    .live_count_o    (live_count_o)
  );

endmodule

`default_nettype wire

// ===== hdl/rha_ctrl.sv =====
// ----------------------------------------------------------------------------
// rha_ctrl
// Two-state sequencer: read cycle on acceptance, write-back cycle after it.
// ----------------------------------------------------------------------------
`default_nettype none

module rha_ctrl
  import rha_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output ctrl_cmd_t cmd_o,
  output logic      busy_o,
  output logic      done_o
);

  fsm_state_e state_q, state_d;
  logic       done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.exec;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o.load  = 1'b0;
    cmd_o.exec  = 1'b0;
    busy_o      = 1'b0;
    case (state_q)
      FSM_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        cmd_o.exec = 1'b1;
        busy_o     = 1'b1;
        state_d    = FSM_IDLE;
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== hdl/rha_datapath.sv =====
// ----------------------------------------------------------------------------
// rha_datapath
// Entry memories, free list head, fill index, live total and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "refcounted_handle_allocator_defines.svh"

module rha_datapath
  import rha_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ctrl_cmd_t         cmd_i,
  input  wire logic [ACT_W-1:0]  action_i,
  input  wire logic [IDX_W-1:0]  handle_i,
  input  wire logic [VAL_W-1:0]  oop_value_i,
  input  wire logic              cfg_we_i,
  input  wire logic [SLAB_W-1:0] cfg_wdata_i,
  output logic [STAT_W-1:0]      status_o,
  output logic [IDX_W-1:0]       result_handle_o,
  output logic [VAL_W-1:0]       result_value_o,
  output logic [CNT_W-1:0]       ref_count_o,
  output logic [LIVE_W-1:0]      live_count_o
);

  logic [VAL_W-1:0] val_mem  [TABLE_DEPTH];
  logic [CNT_W-1:0] cnt_mem  [TABLE_DEPTH];
  logic [IDX_W-1:0] link_mem [TABLE_DEPTH];

  logic [LIVE_W-1:0] cap_q;
  logic [IDX_W-1:0]  head_q, head_d;
  logic              empty_q, empty_d;
  logic [LIVE_W-1:0] fresh_q, fresh_d;
  logic [LIVE_W-1:0] live_q, live_d;

  action_e          act_q;
  logic [IDX_W-1:0] addr_q;
  logic [VAL_W-1:0] oop_q;
  logic             cnt_valid_q;
  logic [VAL_W-1:0] val_rd_q;
  logic [CNT_W-1:0] cnt_rd_q;
  logic [IDX_W-1:0] link_rd_q;

  logic [IDX_W-1:0] rd_addr;
  logic [CNT_W-1:0] cnt_cur;
  logic             val_we, cnt_we, link_we;
  logic [CNT_W-1:0] cnt_wdata;
  status_e          stat_d;
  logic [IDX_W-1:0] res_h_d;
  logic [VAL_W-1:0] res_v_d;
  logic [CNT_W-1:0] res_c_d;
  logic             dead_exec;

  always_comb begin
    if (action_e'(action_i) == ACT_CREATE) begin
      rd_addr = empty_q ? fresh_q[IDX_W-1:0] : head_q;
    end else begin
      rd_addr = handle_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_rd_q    <= val_mem[rd_addr];
      cnt_rd_q    <= cnt_mem[rd_addr];
      link_rd_q   <= link_mem[rd_addr];
      act_q       <= action_e'(action_i);
      addr_q      <= rd_addr;
      oop_q       <= oop_value_i;
      cnt_valid_q <= ({1'b0, rd_addr} < fresh_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[addr_q] <= oop_q;
    end
    if (cnt_we) begin
      cnt_mem[addr_q] <= cnt_wdata;
    end
    if (link_we) begin
      link_mem[addr_q] <= head_q;
    end
  end

  assign cnt_cur = cnt_valid_q ? cnt_rd_q : '0;

  always_comb begin
    head_d    = head_q;
    empty_d   = empty_q;
    fresh_d   = fresh_q;
    live_d    = live_q;
    val_we    = 1'b0;
    cnt_we    = 1'b0;
    link_we   = 1'b0;
    cnt_wdata = cnt_cur;
    stat_d    = ST_OK;
    res_h_d   = addr_q;
    res_v_d   = '0;
    res_c_d   = '0;
    if (act_q == ACT_CREATE) begin
      if (!empty_q) begin
        head_d = link_rd_q;
      end else if (fresh_q < cap_q) begin
        fresh_d = fresh_q + LIVE_W'(1);
      end else begin
        stat_d  = ST_FULL;
        res_h_d = '0;
      end
      if (stat_d == ST_OK) begin
        val_we    = cmd_i.exec;
        cnt_we    = cmd_i.exec;
        cnt_wdata = CNT_W'(1);
        live_d    = live_q + LIVE_W'(1);
        empty_d   = (fresh_d == live_d);
        res_v_d   = oop_q;
        res_c_d   = CNT_W'(1);
      end
    end else if (cnt_cur == '0) begin
      stat_d = ST_DEAD;
    end else begin
      case (act_q)
        ACT_GET: begin
          res_v_d = val_rd_q;
          res_c_d = cnt_cur;
        end
        ACT_RETAIN: begin
          res_v_d = val_rd_q;
          if (cnt_cur == COUNT_MAX) begin
            stat_d  = ST_OVERFLOW;
            res_c_d = COUNT_MAX;
          end else begin
            cnt_we    = cmd_i.exec;
            cnt_wdata = cnt_cur + CNT_W'(1);
            res_c_d   = cnt_wdata;
          end
        end
        ACT_RELEASE: begin
          cnt_we    = cmd_i.exec;
          cnt_wdata = cnt_cur - CNT_W'(1);
          res_c_d   = cnt_wdata;
          if (cnt_wdata == '0) begin
            link_we = cmd_i.exec;
            head_d  = addr_q;
            empty_d = 1'b0;
            live_d  = live_q - LIVE_W'(1);
          end else begin
            res_v_d = val_rd_q;
          end
        end
        default: begin
          stat_d = ST_DEAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= cap_of(SLAB_LIMIT_RST);
      head_q  <= '0;
      empty_q <= 1'b1;
      fresh_q <= '0;
      live_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cap_of(cfg_wdata_i);
      end
      if (cmd_i.exec) begin
        head_q  <= head_d;
        empty_q <= empty_d;
        fresh_q <= fresh_d;
        live_q  <= live_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_o        <= stat_d;
      result_handle_o <= res_h_d;
      result_value_o  <= res_v_d;
      ref_count_o     <= res_c_d;
      live_count_o    <= live_d;
    end
  end

  assign dead_exec = cmd_i.exec && (stat_d == ST_DEAD);

  `RHA_ASSERT_NOW(a_live_le_fresh, 1'b1, live_q <= fresh_q, "live total above fill index")
  `RHA_ASSERT_NOW(a_empty_tracks, 1'b1, empty_q == (fresh_q == live_q), "free list flag out of step")
  `RHA_ASSERT_NEXT(a_dead_clean, dead_exec, ~|{ref_count_o, result_value_o}, "dead result nonzero")

endmodule

`default_nettype wire
